/* src/pngdf_pkg.sv */
// Shared types, codes and arithmetic helpers for the PNG scanline defilter.
// Depends on nothing; used by png_scanline_defilter.
package pngdf_pkg;

    // Filter type codes carried in the first byte of each row.
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b1;

    localparam int IMG_WIDTH_W = 11;
    localparam int BPP_W       = 3;

    localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET = 11'd1;
    localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd4;

    // Paeth predictor: pick the neighbor closest to a + b - c, ties to a, then b.
    function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [9:0]         pa;
        logic [9:0]         pb;
        logic [9:0]         pc;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b})
             - $signed({2'b00, c, 1'b0});
        pa = da[10] ? 10'(-da) : da[9:0];
        pb = db[10] ? 10'(-db) : db[9:0];
        pc = dc[10] ? 10'(-dc) : dc[9:0];
        if ((pa <= pb) && (pa <= pc))
        begin
            paeth_pred = a;
        end
        else if (pb <= pc)
        begin
            paeth_pred = b;
        end
        else
        begin
            paeth_pred = c;
        end
    endfunction

endpackage

/* src/png_scanline_defilter.sv */
// PNG scanline defilter top level: row control, previous-row line buffer and
// reconstruction datapath. Depends on pngdf_pkg.
//
// Takes one inflated byte per request and returns one reconstructed byte per
// data byte, sustaining one byte per clock unless out_stall holds the output
// register; a byte's result comes from the synchronous line-buffer read and
// stage 1, then the output register. The first byte of every row is the
// filter type (None, Sub, Up, Average, Paeth) and gives no result; a type
// above 4 gives a single result with bad_filter set and the block then drops
// bytes until start_of_image marks a new first row. The line buffer holds
// MAX_WIDTH * 4 bytes of the previous row in one memory read and written
// once per byte; it has no reset and needs no clearing pass, because rows of
// one image share a width and the first row reads the buffer as zero. The
// left and upper-left neighbors come from a four-deep byte history next to
// the adder, so the Sub/Paeth feedback needs no line-buffer read. Write
// image_width and bytes_per_pixel only while the block is idle; a width of
// 0 acts as 1, a width above MAX_WIDTH as MAX_WIDTH, and a pixel size below 4
// acts as 3 bytes.
module png_scanline_defilter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pngdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pngdf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input byte stream
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               start_of_image,
    // reconstructed byte stream
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         recon_byte,
    output logic                               end_of_row,
    output logic                               bad_filter
);

    localparam int ROW_MAX = MAX_WIDTH * 4;
    localparam int XW      = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CW      = $clog2(ROW_MAX + 1);
    localparam int SW      = (CW > pngdf_pkg::IMG_WIDTH_W) ? CW : pngdf_pkg::IMG_WIDTH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pngdf_pkg::IMG_WIDTH_W-1:0] image_width_reg;
    logic [pngdf_pkg::BPP_W-1:0]       bpp_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= pngdf_pkg::IMG_WIDTH_RESET;
            bpp_cfg_reg     <= pngdf_pkg::BPP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pngdf_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[pngdf_pkg::IMG_WIDTH_W-1:0];
                pngdf_pkg::CFG_BYTES_PER_PIXEL:
                    bpp_cfg_reg <= cfg_data[pngdf_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective pixel size and row length in bytes.
    logic          bpp4;
    logic [SW-1:0] width_ext;
    logic [CW-1:0] eff_width;
    logic [CW-1:0] stride;

    assign bpp4      = (bpp_cfg_reg >= 3'd4);
    assign width_ext = SW'(image_width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            eff_width = CW'(1);
        end
        else if (width_ext > SW'(MAX_WIDTH))
        begin
            eff_width = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext[CW-1:0];
        end
        stride = bpp4 ? (eff_width << 2) : ((eff_width << 1) + eff_width);
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 holds one byte after the line-buffer read, the
    // output register holds one result; both advance unless the output
    // is full and stalled.
    // ------------------------------------------------------------------
    logic          out_valid_reg;
    logic          out_free;
    logic          s1_valid_reg;
    logic          s1_go;
    logic          s1_hold;
    logic          in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign s1_hold  = s1_valid_reg && !out_free;
    assign in_stall = s1_hold;
    assign in_fire  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Stage 0: row control (filter byte, column count, halt)
    // ------------------------------------------------------------------
    logic [CW-1:0] column_reg;
    logic [CW-1:0] column_next;
    logic [2:0]    row_filter_reg;
    logic [2:0]    row_filter_next;
    logic          first_row_reg;
    logic          first_row_next;
    logic          halted_reg;
    logic          halted_next;

    logic          is_bad;
    logic          emit_data;
    logic          emit_bad;
    logic [CW-1:0] col_m1;
    logic [XW-1:0] in_x;
    logic          in_last;
    logic          in_has_left;

    assign is_bad      = (data_byte > {5'b00000, pngdf_pkg::FILT_PAETH});
    assign col_m1      = column_reg - CW'(1);
    assign in_x        = col_m1[XW-1:0];
    assign in_last     = (column_reg >= stride);
    assign in_has_left = bpp4 ? (column_reg > CW'(4)) : (column_reg > CW'(3));

    always_comb
    begin
        column_next     = column_reg;
        row_filter_next = row_filter_reg;
        first_row_next  = first_row_reg;
        halted_next     = halted_reg;
        emit_data       = 1'b0;
        emit_bad        = 1'b0;
        if (in_fire)
        begin
            if (start_of_image || (!halted_reg && (column_reg == '0)))
            begin
                // Filter byte: begin a row, or halt on an unknown type.
                if (start_of_image)
                begin
                    first_row_next = 1'b1;
                end
                if (is_bad)
                begin
                    halted_next     = 1'b1;
                    row_filter_next = pngdf_pkg::FILT_NONE;
                    column_next     = '0;
                    emit_bad        = 1'b1;
                end
                else
                begin
                    halted_next     = 1'b0;
                    row_filter_next = data_byte[2:0];
                    column_next     = CW'(1);
                end
            end
            else if (!halted_reg)
            begin
                emit_data = 1'b1;
                if (in_last)
                begin
                    column_next    = '0;
                    first_row_next = 1'b0;
                end
                else
                begin
                    column_next = column_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            row_filter_reg <= pngdf_pkg::FILT_NONE;
            first_row_reg  <= 1'b1;
            halted_reg     <= 1'b0;
        end
        else
        begin
            column_reg     <= column_next;
            row_filter_reg <= row_filter_next;
            first_row_reg  <= first_row_next;
            halted_reg     <= halted_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: the byte waiting for its upper neighbor
    // ------------------------------------------------------------------
    logic          s1_valid_next;
    logic          s1_bad_reg;
    logic [7:0]    s1_byte_reg;
    logic [XW-1:0] s1_x_reg;
    logic [2:0]    s1_filter_reg;
    logic          s1_first_reg;
    logic          s1_last_reg;
    logic          s1_left_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (emit_data || emit_bad)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_data || emit_bad)
        begin
            s1_bad_reg    <= emit_bad;
            s1_byte_reg   <= data_byte;
            s1_x_reg      <= in_x;
            s1_filter_reg <= row_filter_reg;
            s1_first_reg  <= first_row_reg;
            s1_last_reg   <= in_last;
            s1_left_reg   <= in_has_left;
        end
    end

    // ------------------------------------------------------------------
    // Previous-row line buffer. Read the new byte's column, or re-read the
    // held byte's column while stage 1 stalls. Forward a write that lands
    // on the address being read in the same cycle.
    // ------------------------------------------------------------------
    logic [7:0]    line_mem [ROW_MAX];
    logic [7:0]    mem_q;
    logic [XW-1:0] rd_addr;
    logic          mem_we;
    logic [7:0]    recon;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    assign rd_addr = s1_hold ? s1_x_reg : in_x;
    assign mem_we  = s1_go && !s1_bad_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[s1_x_reg] <= recon;
        end
        mem_q        <= line_mem[rd_addr];
        fwd_hit_reg  <= mem_we && (s1_x_reg == rd_addr);
        fwd_data_reg <= recon;
    end

    // ------------------------------------------------------------------
    // Reconstruction: neighbors, predictor and the byte history
    // ------------------------------------------------------------------
    logic [7:0] left_hist_reg [4];
    logic [7:0] upl_hist_reg  [4];
    logic [7:0] nb_a;
    logic [7:0] nb_b;
    logic [7:0] nb_c;
    logic [8:0] avg_sum;
    logic [7:0] pred;

    always_comb
    begin
        nb_b = s1_first_reg ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : mem_q);
        nb_a = 8'd0;
        nb_c = 8'd0;
        if (s1_left_reg)
        begin
            nb_a = bpp4 ? left_hist_reg[3] : left_hist_reg[2];
            if (!s1_first_reg)
            begin
                nb_c = bpp4 ? upl_hist_reg[3] : upl_hist_reg[2];
            end
        end
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (s1_filter_reg)
            pngdf_pkg::FILT_NONE:  pred = 8'd0;
            pngdf_pkg::FILT_SUB:   pred = nb_a;
            pngdf_pkg::FILT_UP:    pred = nb_b;
            pngdf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngdf_pkg::FILT_PAETH: pred = pngdf_pkg::paeth_pred(nb_a, nb_b, nb_c);
            default:               pred = 8'd0;
        endcase
        recon = s1_byte_reg + pred;
    end

    // Advance the history only on data bytes; within a row the entries
    // used are always bytes of that row, so a row start needs no clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                left_hist_reg[i] <= 8'd0;
                upl_hist_reg[i]  <= 8'd0;
            end
        end
        else if (mem_we)
        begin
            for (int i = 3; i > 0; i--)
            begin
                left_hist_reg[i] <= left_hist_reg[i-1];
                upl_hist_reg[i]  <= upl_hist_reg[i-1];
            end
            left_hist_reg[0] <= recon;
            upl_hist_reg[0]  <= nb_b;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic       out_valid_next;
    logic [7:0] recon_byte_reg;
    logic       end_of_row_reg;
    logic       bad_filter_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            recon_byte_reg <= s1_bad_reg ? 8'd0 : recon;
            end_of_row_reg <= !s1_bad_reg && s1_last_reg;
            bad_filter_reg <= s1_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign recon_byte = recon_byte_reg;
    assign end_of_row = end_of_row_reg;
    assign bad_filter = bad_filter_reg;

`ifndef SYNTH
    // An error result carries no byte and never ends a row.
    a_bad_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_filter) |-> ((recon_byte == 8'd0) && !end_of_row))
        else $error("error result with nonzero byte or end_of_row");

    // An unknown filter type on an image start leaves the block halted.
    a_bad_filter_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && start_of_image && is_bad) |=> halted_reg)
        else $error("unknown filter type did not halt");

    // The column count never runs past the line buffer.
    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= CW'(ROW_MAX))
        else $error("column beyond line buffer");

    // A held stage-1 byte keeps its column so the re-read hits the same entry.
    a_s1_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        s1_hold |=> (s1_valid_reg && $stable(s1_x_reg) && $stable(s1_bad_reg)))
        else $error("stage 1 changed while held");
`endif

endmodule
